/* rtl/wrs_pkg.sv */
// Shared constants, types and helpers for the weighted rank scan core.
package wrs_pkg;

   localparam int PROB_FRAC_BITS = 16;
   localparam int MAX_IND        = 4096;
   localparam int CFG_W          = 13;
   localparam int PROB_W         = 17;
   localparam int RANK_W         = 14;
   localparam int LOD_W          = 48;
   localparam int SUM_P_W        = 29;
   localparam int SUM_Q_W        = 45;
   localparam int SUM_R_W        = 43;
   localparam int TOT_W          = 64;
   localparam int CNT_W          = 13;
   localparam int DIST_W         = 43;
   localparam int NN1_W          = 25;
   localparam int MUL_W          = 152;
   localparam int MUL_B_W        = 64;
   localparam int DIV_W          = 128;
   localparam int QUO_W          = 64;
   localparam int STEP_W         = 8;

   localparam logic [PROB_W-1:0]  PROB_ONE   = PROB_W'(1 << PROB_FRAC_BITS);
   localparam logic [CFG_W-1:0]   IND_MIN    = CFG_W'(2);
   localparam logic [CFG_W-1:0]   IND_MAX    = CFG_W'(MAX_IND);
   localparam logic [CFG_W-1:0]   IND_RESET  = CFG_W'(2);
   localparam logic [30:0]        INV_LN10   = 31'd1865280597;
   localparam logic [STEP_W-1:0]  TERM_STEPS = STEP_W'(DIV_W + 31 - PROB_FRAC_BITS);
   localparam logic [STEP_W-1:0]  LOD_STEPS  = STEP_W'(DIV_W);
   localparam logic [LOD_W-1:0]   LOD_MAX    = {LOD_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_CHECK,
      ST_MUL_SQ,
      ST_MUL_WGT,
      ST_DIV_TERM,
      ST_ADD,
      ST_LOD_START,
      ST_LOD_MUL,
      ST_LOD_DIV,
      ST_EMIT
   } wrs_state_type;

   typedef struct packed {
      logic ready;
      logic accept;
      logic close;
      logic skip;
      logic mul_sq;
      logic mul_wgt;
      logic mul_lod;
      logic div_term;
      logic div_lod;
      logic add_term;
      logic emit;
   } wrs_cmd_type;

   typedef struct packed {
      logic group_end;
      logic last;
      logic den_zero;
      logic mul_busy;
      logic div_busy;
      logic ovf;
      logic out_free;
   } wrs_sts_type;

   function automatic logic [CFG_W-1:0] group_size(input logic [CFG_W-1:0] cnt);
      logic [CFG_W-1:0] n;
      n = cnt;
      if (cnt < IND_MIN) n = IND_MIN;
      else if (cnt > IND_MAX) n = IND_MAX;
      return n;
   endfunction

endpackage

/* rtl/wrs_req_if.sv */
// Input channel: probability and doubled rank per individual.
interface wrs_req_if;
   logic                          valid;
   logic                          ready;
   logic [wrs_pkg::PROB_W-1:0]    prob;
   logic [wrs_pkg::RANK_W-1:0]    rank_x2;
   logic                          last_of_position;

   modport source (output valid, prob, rank_x2, last_of_position, input ready);
   modport sink   (input valid, prob, rank_x2, last_of_position, output ready);
endinterface

/* rtl/wrs_rsp_if.sv */
// Result channel: position LOD score and degenerate flag.
interface wrs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wrs_pkg::LOD_W-1:0]    lod;
   logic                         degenerate;

   modport source (output valid, lod, degenerate, input ready);
   modport sink   (input valid, lod, degenerate, output ready);
endinterface

/* rtl/weighted_rank_scan_statistic_core.sv */
// Top level of the weighted rank scan statistic core.
//
//   channel  | dir | payload                               | transaction
//   req_if   | in  | prob[16:0] rank_x2[13:0] last_of_pos. | valid & ready
//   rsp_if   | out | lod[47:0] degenerate                  | valid & ready
//   csr      | in  | csr_wdata[12:0] (ind_count)           | csr_we
//
// An item that does not end its group leaves the core ready for the next. A group
// end adds close and check states and, unless the denominator is zero, two
// shift-add multiplies and, unless the term overflows, a divide; a position end
// adds a multiply and a divide in the same serial units. Synchronous reset sets
// ind_count to 2 and clears all sums. req ready is low outside idle: while a group
// closes, the LOD is scaled or a result waits for a free output register.
module weighted_rank_scan_statistic_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [wrs_pkg::CFG_W-1:0]   csr_wdata,
   wrs_req_if.sink                     req_if,
   wrs_rsp_if.source                   rsp_if
);
   import wrs_pkg::*;

   wrs_cmd_type cmd;
   wrs_sts_type sts;

   wrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   wrs_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .prob             (req_if.prob),
      .rank_x2          (req_if.rank_x2),
      .last_of_position (req_if.last_of_position),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .lod              (rsp_if.lod),
      .degenerate       (rsp_if.degenerate)
   );

   assign req_if.ready = cmd.ready;
endmodule

/* rtl/wrs_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, stops when multiplier is empty.
module wrs_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wrs_pkg::MUL_W-1:0]   a,
   input  logic [wrs_pkg::MUL_B_W-1:0] b,
   output logic                        busy,
   output logic [wrs_pkg::MUL_W-1:0]   p
);
   import wrs_pkg::*;

   logic [MUL_W-1:0]   a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [MUL_W-1:0]   p_ff, p_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      if (start) begin
         a_in = a;
         b_in = b;
         p_in = '0;
      end else if (b_ff != '0) begin
         if (b_ff[0]) p_in = p_ff + a_ff;
         a_in = {a_ff[MUL_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[MUL_B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= b_in;
      end
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign busy = (b_ff != '0);
   assign p    = p_ff;
endmodule

/* rtl/wrs_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturates at 64 bits.
module wrs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wrs_pkg::DIV_W-1:0]    num,
   input  logic [wrs_pkg::DIV_W-1:0]    den,
   input  logic [wrs_pkg::STEP_W-1:0]   steps,
   output logic                         busy,
   output logic [wrs_pkg::QUO_W-1:0]    result
);
   import wrs_pkg::*;

   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              sat_ff, sat_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]    shifted;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, num_ff[DIV_W-1]};
      ge      = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         quo_in = '0;
         sat_in = 1'b0;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         // bits past the dividend shift in as zeros
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         sat_in = sat_ff | quo_ff[QUO_W-1];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         rem_in = ge ? DIV_W'(shifted - {1'b0, den_ff}) : shifted[DIV_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign busy   = (cnt_ff != '0);
   assign result = sat_ff ? {QUO_W{1'b1}} : quo_ff;
endmodule

/* rtl/wrs_datapath.sv */
// Datapath: accumulators, group-close arithmetic, position total and result register.
module wrs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [wrs_pkg::CFG_W-1:0]   csr_wdata,
   input  wrs_pkg::wrs_cmd_type        cmd,
   output wrs_pkg::wrs_sts_type        sts,
   input  logic [wrs_pkg::PROB_W-1:0]  prob,
   input  logic [wrs_pkg::RANK_W-1:0]  rank_x2,
   input  logic                        last_of_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [wrs_pkg::LOD_W-1:0]   lod,
   output logic                        degenerate
);
   import wrs_pkg::*;

   logic [CFG_W-1:0]   ind_count_ff;
   logic [SUM_P_W-1:0] sum_p_ff;
   logic [SUM_Q_W-1:0] sum_q_ff;
   logic [SUM_R_W-1:0] sum_r_ff;
   logic [CNT_W-1:0]   items_ff;
   logic [TOT_W-1:0]   total_ff;
   logic               skip_ff;
   logic               last_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [DIV_W-1:0]   den_ff;
   logic [MUL_B_W-1:0] wgt_ff;
   logic [NN1_W-1:0]   nn1_ff;
   logic [LOD_W-1:0]   lod_ff;
   logic               degen_ff;
   logic               rsp_valid_ff;

   logic [CFG_W-1:0]   n_cur;
   logic [PROB_W-1:0]  p_sat;
   logic [41:0]        np1s;
   logic [57:0]        nq;
   logic [57:0]        ss;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_W-1:0]   mul_p;
   logic               mul_busy;
   logic [MUL_W+1:0]   num3;
   logic               ovf;
   logic [DIV_W-1:0]   div_num;
   logic [DIV_W-1:0]   div_den;
   logic [STEP_W-1:0]  div_steps;
   logic [QUO_W-1:0]   div_res;
   logic               div_busy;
   logic [TOT_W-1:0]   term;
   logic [TOT_W:0]     tot_sum;

   assign n_cur = group_size(ind_count_ff);
   assign p_sat = (prob > PROB_ONE) ? PROB_ONE : prob;
   assign np1s  = 42'({1'b0, n_cur} + 14'd1) * 42'(sum_p_ff);
   assign nq    = 58'(n_cur) * 58'(sum_q_ff);
   assign ss    = 58'(sum_p_ff) * 58'(sum_p_ff);

   always_comb begin
      if (cmd.mul_sq) begin
         mul_a = MUL_W'(dist_ff);
         mul_b = MUL_B_W'(dist_ff);
      end else if (cmd.mul_wgt) begin
         mul_a = mul_p;
         mul_b = wgt_ff;
      end else begin
         mul_a = MUL_W'(total_ff);
         mul_b = MUL_B_W'(INV_LN10);
      end
   end

   wrs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_sq | cmd.mul_wgt | cmd.mul_lod),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .p     (mul_p)
   );

   // three times the weighted square; anything at or past 2^128 saturates the term
   assign num3 = {2'b00, mul_p} + {1'b0, mul_p, 1'b0};
   assign ovf  = (num3[MUL_W+1:DIV_W] != '0);

   always_comb begin
      if (cmd.div_term) begin
         div_num   = num3[DIV_W-1:0];
         div_den   = den_ff;
         div_steps = TERM_STEPS;
      end else begin
         div_num   = DIV_W'(mul_p[DIV_W-1:48]);
         div_den   = DIV_W'(nn1_ff);
         div_steps = LOD_STEPS;
      end
   end

   wrs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_term | cmd.div_lod),
      .num    (div_num),
      .den    (div_den),
      .steps  (div_steps),
      .busy   (div_busy),
      .result (div_res)
   );

   assign term    = ovf ? {TOT_W{1'b1}} : div_res;
   assign tot_sum = {1'b0, total_ff} + {1'b0, term};

   always_ff @(posedge clock) begin
      if (reset) begin
         ind_count_ff <= IND_RESET;
         sum_p_ff     <= '0;
         sum_q_ff     <= '0;
         sum_r_ff     <= '0;
         items_ff     <= '0;
         total_ff     <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) ind_count_ff <= csr_wdata;
         if (cmd.accept) begin
            sum_p_ff <= sum_p_ff + SUM_P_W'(p_sat);
            sum_q_ff <= sum_q_ff + SUM_Q_W'(p_sat * p_sat);
            sum_r_ff <= sum_r_ff + SUM_R_W'(p_sat * rank_x2);
            items_ff <= items_ff + CNT_W'(1);
         end else if (cmd.close) begin
            sum_p_ff <= '0;
            sum_q_ff <= '0;
            sum_r_ff <= '0;
            items_ff <= '0;
         end
         if (cmd.skip) skip_ff <= 1'b1;
         if (cmd.add_term) total_ff <= tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
         if (cmd.emit) begin
            total_ff     <= '0;
            skip_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) last_ff <= last_of_position;
      if (cmd.close) begin
         dist_ff <= (sum_r_ff >= SUM_R_W'(np1s)) ? DIST_W'(sum_r_ff - SUM_R_W'(np1s))
                                                 : DIST_W'(SUM_R_W'(np1s) - sum_r_ff);
         den_ff  <= DIV_W'(nq) - DIV_W'(ss);
         wgt_ff  <= MUL_B_W'({n_cur, PROB_FRAC_BITS'(0)}) - MUL_B_W'(sum_p_ff);
         nn1_ff  <= NN1_W'(n_cur) * NN1_W'({1'b0, n_cur} + 14'd1);
      end
      if (cmd.emit) begin
         lod_ff   <= (div_res > QUO_W'(LOD_MAX)) ? LOD_MAX : div_res[LOD_W-1:0];
         degen_ff <= skip_ff;
      end
   end

   always_comb begin
      sts.group_end = ({1'b0, items_ff} + 14'd1) >= {1'b0, n_cur};
      sts.last      = last_ff;
      sts.den_zero  = (den_ff == '0);
      sts.mul_busy  = mul_busy;
      sts.div_busy  = div_busy;
      sts.ovf       = ovf;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign lod        = lod_ff;
   assign degenerate = degen_ff;
endmodule

/* rtl/wrs_ctrl.sv */
// Controller: sequences accumulation, group close, term division and LOD scaling.
module wrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  wrs_pkg::wrs_sts_type  sts,
   output wrs_pkg::wrs_cmd_type  cmd
);
   import wrs_pkg::*;

   wrs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.group_end) state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.den_zero) begin
               cmd.skip = 1'b1;
               state_in = sts.last ? ST_LOD_START : ST_IDLE;
            end else begin
               cmd.mul_sq = 1'b1;
               state_in   = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (!sts.mul_busy) begin
               cmd.mul_wgt = 1'b1;
               state_in    = ST_MUL_WGT;
            end
         end
         ST_MUL_WGT: begin
            if (!sts.mul_busy) begin
               if (sts.ovf) begin
                  state_in = ST_ADD;
               end else begin
                  cmd.div_term = 1'b1;
                  state_in     = ST_DIV_TERM;
               end
            end
         end
         ST_DIV_TERM: begin
            if (!sts.div_busy) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_term = 1'b1;
            state_in     = sts.last ? ST_LOD_START : ST_IDLE;
         end
         ST_LOD_START: begin
            cmd.mul_lod = 1'b1;
            state_in    = ST_LOD_MUL;
         end
         ST_LOD_MUL: begin
            if (!sts.mul_busy) begin
               cmd.div_lod = 1'b1;
               state_in    = ST_LOD_DIV;
            end
         end
         ST_LOD_DIV: begin
            if (!sts.div_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* rtl/wrs_checker.sv */
// Port-level checks for the weighted rank scan core, bound to the top level.
module wrs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wrs_pkg::LOD_W-1:0]   rsp_lod,
   input logic                        rsp_degenerate
);
   // a result only rises when input was held off just before it
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while input was being taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_lod) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("core not idle after reset");
endmodule

bind weighted_rank_scan_statistic_core wrs_checker u_wrs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_lod        (rsp_if.lod),
   .rsp_degenerate (rsp_if.degenerate)
);
